FILE: hdl/paged_packet_fifo_unit_defines.svh
// Assertion macros for the checker file of the paged packet FIFO.
`ifndef PAGED_PACKET_FIFO_UNIT_DEFINES_SVH
`define PAGED_PACKET_FIFO_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("paged packet fifo check failed");

// Next-cycle implication, checked outside reset.
`define PPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("paged packet fifo check failed");

`endif

FILE: hdl/ppf_pkg.sv
`default_nettype none
package ppf_pkg;

    localparam int MAX_PAGE_BYTES = 64;
    localparam int MAX_PAGES      = 16;

    localparam int IDX_W  = (MAX_PAGE_BYTES > 1) ? $clog2(MAX_PAGE_BYTES) : 1;
    localparam int SLOT_W = $clog2(MAX_PAGES);
    localparam int LEN_W  = $clog2(MAX_PAGE_BYTES + 1);
    localparam int OCC_W  = $clog2(MAX_PAGES + 1);

    // Widths fixed by the interface.
    localparam int PB_W       = 7;
    localparam int PIU_W      = 5;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int PU_W       = 5;
    localparam int MLEN_W     = 7;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGES_IN_USE = 2'd1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] STAT_COMMIT = 2'd0;
    localparam logic [1:0] STAT_REJECT = 2'd1;
    localparam logic [1:0] STAT_DATA   = 2'd2;
    localparam logic [1:0] STAT_EMPTY  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_LEN,
        ST_RD_DATA
    } t_state;

endpackage
`default_nettype wire

FILE: hdl/paged_packet_fifo_unit.sv
`default_nettype none
// Write words are taken back to back while the output is free; an end-marked one shows its
// result in the next cycle. A page read goes through the page length memory read register, then
// the byte memory read register (not for an empty page), then one byte per cycle to the output
// register unless it stalls; output stalls hold the byte memory read register. Reset (synchronous,
// active low) clears pointers, counts and output valid, sets size registers to maximum; memories keep contents.
module paged_packet_fifo_unit (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [ppf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [ppf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire                            i_opcode,
    input  wire [7:0]                      i_data_byte,
    input  wire                            i_byte_present,
    input  wire                            i_end_of_message,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [1:0]                     o_status,
    output logic [7:0]                     o_read_byte,
    output logic                           o_read_byte_valid,
    output logic [ppf_pkg::MLEN_W-1:0]     o_message_length,
    output logic                           o_last_of_run,
    output logic [ppf_pkg::PU_W-1:0]       o_pages_used
);

    localparam int SLOT_W = ppf_pkg::SLOT_W;
    localparam int IDX_W  = ppf_pkg::IDX_W;
    localparam int LEN_W  = ppf_pkg::LEN_W;
    localparam int OCC_W  = ppf_pkg::OCC_W;
    localparam int ADDR_W = SLOT_W + IDX_W;

    // Memories
    logic [7:0]       r_store [0:(1 << ADDR_W)-1];
    logic [LEN_W-1:0] r_plen  [0:ppf_pkg::MAX_PAGES-1];
    logic [7:0]       r_store_q;
    logic [LEN_W-1:0] r_plen_q;

    // Control state
    ppf_pkg::t_state r_state, n_state;
    logic [ppf_pkg::PB_W-1:0]  r_pb, n_pb;
    logic [ppf_pkg::PIU_W-1:0] r_piu, n_piu;
    logic [SLOT_W-1:0] r_ws, n_ws, r_rs, n_rs, r_slot, n_slot;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic              r_ovr, n_ovr;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_ovld, n_ovld;

    // Output payload
    logic [1:0]                r_status;
    logic [7:0]                r_rbyte;
    logic                      r_rbv;
    logic [ppf_pkg::MLEN_W-1:0] r_mlen;
    logic                      r_last;
    logic [ppf_pkg::PU_W-1:0]  r_pused;

    // Combinational controls
    logic              out_free, accept, emit;
    logic [1:0]        e_status;
    logic [7:0]        e_rbyte;
    logic              e_rbv;
    logic [LEN_W-1:0]  e_len;
    logic              e_last;
    logic [OCC_W-1:0]  e_occ;
    logic              store_we, store_re, plen_we, plen_re;
    logic [ADDR_W-1:0] store_waddr, store_raddr;
    logic [LEN_W-1:0]  plen_wdata, len_commit;
    logic [LEN_W-1:0]  eff_bytes;
    logic [OCC_W-1:0]  eff_pages;
    logic              full, store_cond, last_byte;

    function automatic logic [SLOT_W-1:0] f_next(input logic [SLOT_W-1:0] s,
                                                 input logic [OCC_W-1:0]  ep);
        logic [SLOT_W:0] n;
        n = {1'b0, s} + 1'b1;
        return (n >= (SLOT_W + 1)'(ep)) ? '0 : n[SLOT_W-1:0];
    endfunction

    always_comb begin
        if (r_pb == '0) begin
            eff_bytes = LEN_W'(1);
        end else if (r_pb > ppf_pkg::MAX_PAGE_BYTES) begin
            eff_bytes = LEN_W'(ppf_pkg::MAX_PAGE_BYTES);
        end else begin
            eff_bytes = LEN_W'(r_pb);
        end
        if (r_piu == '0) begin
            eff_pages = OCC_W'(1);
        end else if (r_piu > ppf_pkg::MAX_PAGES) begin
            eff_pages = OCC_W'(ppf_pkg::MAX_PAGES);
        end else begin
            eff_pages = OCC_W'(r_piu);
        end
    end

    assign full       = (r_occ >= eff_pages);
    assign out_free   = !r_ovld || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign store_cond = i_byte_present && (r_cnt < eff_bytes);
    assign last_byte  = ((LEN_W'(r_idx) + 1'b1) == r_plen_q);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppf_pkg::ST_IDLE: begin
                if (accept && (i_opcode == ppf_pkg::OP_READ) && (r_occ != '0)) begin
                    n_state = ppf_pkg::ST_RD_LEN;
                end
            end
            ppf_pkg::ST_RD_LEN: begin
                if (r_plen_q != '0) begin
                    n_state = ppf_pkg::ST_RD_DATA;
                end else if (out_free) begin
                    n_state = ppf_pkg::ST_IDLE;
                end
            end
            ppf_pkg::ST_RD_DATA: begin
                if (out_free && last_byte) begin
                    n_state = ppf_pkg::ST_IDLE;
                end
            end
            default: n_state = ppf_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        o_in_ready  = 1'b0;
        emit        = 1'b0;
        e_status    = ppf_pkg::STAT_COMMIT;
        e_rbyte     = '0;
        e_rbv       = 1'b0;
        e_len       = '0;
        e_last      = 1'b1;
        e_occ       = r_occ;
        store_we    = 1'b0;
        store_waddr = {r_ws, r_cnt[IDX_W-1:0]};
        store_re    = 1'b0;
        store_raddr = {r_slot, r_idx};
        plen_we     = 1'b0;
        plen_re     = 1'b0;
        len_commit  = '0;
        plen_wdata  = '0;
        n_pb   = r_pb;
        n_piu  = r_piu;
        n_ws   = r_ws;
        n_rs   = r_rs;
        n_occ  = r_occ;
        n_cnt  = r_cnt;
        n_ovr  = r_ovr;
        n_slot = r_slot;
        n_idx  = r_idx;
        case (r_state)
            ppf_pkg::ST_IDLE: begin
                o_in_ready = out_free;
                if (accept && (i_opcode == ppf_pkg::OP_WRITE)) begin
                    if (store_cond) begin
                        if (full) begin
                            n_ovr = 1'b1;
                        end else begin
                            store_we = 1'b1;
                            n_cnt    = r_cnt + 1'b1;
                        end
                    end
                    if (i_end_of_message) begin
                        emit  = 1'b1;
                        n_cnt = '0;
                        n_ovr = 1'b0;
                        if (full || r_ovr) begin
                            e_status = ppf_pkg::STAT_REJECT;
                        end else begin
                            // A lowered page size still caps the open message.
                            len_commit = (store_we ? r_cnt + 1'b1 : r_cnt);
                            if (len_commit > eff_bytes) begin
                                len_commit = eff_bytes;
                            end
                            plen_we    = 1'b1;
                            plen_wdata = len_commit;
                            n_ws       = f_next(r_ws, eff_pages);
                            n_occ      = r_occ + 1'b1;
                            e_occ      = n_occ;
                            e_len      = len_commit;
                        end
                    end
                end else if (accept) begin
                    if (r_occ == '0) begin
                        emit     = 1'b1;
                        e_status = ppf_pkg::STAT_EMPTY;
                    end else begin
                        plen_re = 1'b1;
                        n_slot  = r_rs;
                        n_rs    = f_next(r_rs, eff_pages);
                        n_occ   = r_occ - 1'b1;
                    end
                end
            end
            ppf_pkg::ST_RD_LEN: begin
                if (r_plen_q != '0) begin
                    store_re    = 1'b1;
                    store_raddr = {r_slot, {IDX_W{1'b0}}};
                    n_idx       = '0;
                end else if (out_free) begin
                    emit     = 1'b1;
                    e_status = ppf_pkg::STAT_DATA;
                end
            end
            ppf_pkg::ST_RD_DATA: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_status = ppf_pkg::STAT_DATA;
                    e_rbyte  = r_store_q;
                    e_rbv    = 1'b1;
                    e_len    = r_plen_q;
                    e_last   = last_byte;
                    if (!last_byte) begin
                        store_re    = 1'b1;
                        store_raddr = {r_slot, r_idx + 1'b1};
                        n_idx       = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        // The user must write registers only while the block is idle; the block itself does not enforce this.
        if (i_cfg_we) begin
            if (i_cfg_idx == ppf_pkg::REG_PAGE_BYTES) begin
                n_pb = i_cfg_data[ppf_pkg::PB_W-1:0];
            end else if (i_cfg_idx == ppf_pkg::REG_PAGES_IN_USE) begin
                n_piu = i_cfg_data[ppf_pkg::PIU_W-1:0];
                n_ws  = '0;
                n_rs  = '0;
                n_occ = '0;
                n_cnt = '0;
                n_ovr = 1'b0;
            end
        end
        n_ovld = emit ? 1'b1 : (i_out_ready ? 1'b0 : r_ovld);
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_waddr] <= i_data_byte;
        end
        if (store_re) begin
            r_store_q <= r_store[store_raddr];
        end
        if (plen_we) begin
            r_plen[r_ws] <= plen_wdata;
        end
        if (plen_re) begin
            r_plen_q <= r_plen[r_rs];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppf_pkg::ST_IDLE;
            r_pb    <= ppf_pkg::PB_W'(ppf_pkg::MAX_PAGE_BYTES);
            r_piu   <= ppf_pkg::PIU_W'(ppf_pkg::MAX_PAGES);
            r_ws    <= '0;
            r_rs    <= '0;
            r_occ   <= '0;
            r_cnt   <= '0;
            r_ovr   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pb    <= n_pb;
            r_piu   <= n_piu;
            r_ws    <= n_ws;
            r_rs    <= n_rs;
            r_occ   <= n_occ;
            r_cnt   <= n_cnt;
            r_ovr   <= n_ovr;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_idx  <= n_idx;
        if (emit) begin
            r_status <= e_status;
            r_rbyte  <= e_rbyte;
            r_rbv    <= e_rbv;
            r_mlen   <= ppf_pkg::MLEN_W'(e_len);
            r_last   <= e_last;
            r_pused  <= ppf_pkg::PU_W'(e_occ);
        end
    end

    assign o_out_valid       = r_ovld;
    assign o_status          = r_status;
    assign o_read_byte       = r_rbyte;
    assign o_read_byte_valid = r_rbv;
    assign o_message_length  = r_mlen;
    assign o_last_of_run     = r_last;
    assign o_pages_used      = r_pused;

endmodule
`default_nettype wire

FILE: hdl/ppf_checker.sv
`default_nettype none
`include "paged_packet_fifo_unit_defines.svh"
module ppf_checker (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_out_valid,
    input wire                            i_out_ready,
    input wire [1:0]                      o_status,
    input wire                            o_read_byte_valid,
    input wire [ppf_pkg::MLEN_W-1:0]      o_message_length,
    input wire                            o_last_of_run,
    input wire [ppf_pkg::PU_W-1:0]        o_pages_used
);

    // A stalled word stays offered.
    `PPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // Only a page read carries bytes.
    `PPF_ASSERT_IMPLY(a_byte_is_data, i_clk, i_rst_n, o_out_valid && o_read_byte_valid,
        o_status == ppf_pkg::STAT_DATA && o_message_length != '0)

    // Write results and empty reads are single words.
    `PPF_ASSERT_IMPLY(a_single_word, i_clk, i_rst_n,
        o_out_valid && (o_status == ppf_pkg::STAT_COMMIT || o_status == ppf_pkg::STAT_REJECT ||
        o_status == ppf_pkg::STAT_EMPTY), o_last_of_run && !o_read_byte_valid)

    // An empty FIFO is never reported as holding pages.
    `PPF_ASSERT_IMPLY(a_empty_count, i_clk, i_rst_n,
        o_out_valid && o_status == ppf_pkg::STAT_EMPTY, o_pages_used == '0)

    // Pages used never exceed the ring.
    `PPF_ASSERT_IMPLY(a_pages_bound, i_clk, i_rst_n, o_out_valid,
        o_pages_used <= ppf_pkg::PU_W'(ppf_pkg::MAX_PAGES))

endmodule

bind paged_packet_fifo_unit ppf_checker u_ppf_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_read_byte_valid (o_read_byte_valid),
    .o_message_length  (o_message_length),
    .o_last_of_run     (o_last_of_run),
    .o_pages_used      (o_pages_used)
);
`default_nettype wire

FILE: bench/ppf_word_checker.sv
module ppf_word_checker (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire [ppf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [ppf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                            i_in_valid,
    input  wire                            i_in_ready,
    input  wire                            i_opcode,
    input  wire [7:0]                      i_data_byte,
    input  wire                            i_byte_present,
    input  wire                            i_end_of_message,
    input  wire                            i_out_valid,
    input  wire                            i_out_ready,
    input  wire [1:0]                      i_status,
    input  wire [7:0]                      i_read_byte,
    input  wire                            i_read_byte_valid,
    input  wire [ppf_pkg::MLEN_W-1:0]      i_message_length,
    input  wire                            i_last_of_run,
    input  wire [ppf_pkg::PU_W-1:0]        i_pages_used,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_results_seen
);
    import ppf_pkg::*;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        rbyte;
        logic              rvalid;
        logic [MLEN_W-1:0] length;
        logic              last;
        logic [PU_W-1:0]   used;
    } t_fifo_word;

    t_fifo_word        expected_words[$];
    logic [7:0]        page_mem [MAX_PAGES*MAX_PAGE_BYTES];
    logic [MLEN_W-1:0] page_len [MAX_PAGES];
    int unsigned       fill_slot;
    int unsigned       drain_slot;
    int unsigned       occupied;
    int unsigned       open_bytes;
    bit                open_overrun;
    logic [PB_W-1:0]   page_bytes_reg;
    logic [PIU_W-1:0]  pages_reg;
    int                fails = 0;
    int                results = 0;

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch at word %0d: %s", $time, results, msg);
        fails++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want) flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Out-of-range register values are clamped to the legal range.
    function automatic int unsigned page_capacity();
        if (page_bytes_reg == 0) return 1;
        if (page_bytes_reg > MAX_PAGE_BYTES) return MAX_PAGE_BYTES;
        return page_bytes_reg;
    endfunction

    function automatic int unsigned ring_size();
        if (pages_reg == 0) return 1;
        if (pages_reg > MAX_PAGES) return MAX_PAGES;
        return pages_reg;
    endfunction

    function automatic int unsigned next_page(input int unsigned s);
        return (s + 1 >= ring_size()) ? 0 : s + 1;
    endfunction

    function automatic void clear_ring();
        fill_slot = 0;
        drain_slot = 0;
        occupied = 0;
        open_bytes = 0;
        open_overrun = 1'b0;
    endfunction

    function automatic void push_expected(input logic [1:0] st, input logic [7:0] b,
                                          input logic v, input int unsigned len,
                                          input logic last);
        t_fifo_word w;
        w.status = st;
        w.rbyte = b;
        w.rvalid = v;
        w.length = MLEN_W'(len);
        w.last = last;
        w.used = PU_W'(occupied);
        expected_words.push_back(w);
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        if (idx == REG_PAGE_BYTES) begin
            page_bytes_reg = value[PB_W-1:0];
        end else if (idx == REG_PAGES_IN_USE) begin
            pages_reg = value[PIU_W-1:0];
            clear_ring();
        end
    endfunction

    function automatic void predict_word(input logic op, input logic [7:0] data,
                                         input logic present, input logic eom);
        bit full;
        int unsigned len;
        int unsigned slot;
        full = occupied >= ring_size();
        if (op == OP_WRITE) begin
            if (present && open_bytes < page_capacity()) begin
                // A byte that finds every page taken spoils the whole message.
                if (full) begin
                    open_overrun = 1'b1;
                end else begin
                    page_mem[fill_slot*MAX_PAGE_BYTES + open_bytes] = data;
                    open_bytes++;
                end
            end
            if (eom) begin
                if (full || open_overrun) begin
                    push_expected(STAT_REJECT, 8'h00, 1'b0, 0, 1'b1);
                end else begin
                    len = (open_bytes > page_capacity()) ? page_capacity() : open_bytes;
                    page_len[fill_slot] = MLEN_W'(len);
                    fill_slot = next_page(fill_slot);
                    occupied++;
                    push_expected(STAT_COMMIT, 8'h00, 1'b0, len, 1'b1);
                end
                open_bytes = 0;
                open_overrun = 1'b0;
            end
        end else if (occupied == 0) begin
            push_expected(STAT_EMPTY, 8'h00, 1'b0, 0, 1'b1);
        end else begin
            slot = drain_slot;
            len = page_len[slot];
            drain_slot = next_page(drain_slot);
            occupied--;
            if (len == 0) begin
                push_expected(STAT_DATA, 8'h00, 1'b0, 0, 1'b1);
            end else begin
                for (int i = 0; i < len; i++) begin
                    push_expected(STAT_DATA, page_mem[slot*MAX_PAGE_BYTES + i], 1'b1, len,
                                  i == len - 1);
                end
            end
        end
    endfunction

    task automatic check_word();
        t_fifo_word w;
        if (expected_words.size() == 0) begin
            flag_mismatch($sformatf("no word expected, got status %0d byte %0h",
                                    i_status, i_read_byte));
        end else begin
            w = expected_words.pop_front();
            compare_field("status", 8'(i_status), 8'(w.status));
            compare_field("read_byte", i_read_byte, w.rbyte);
            compare_field("read_byte_valid", 8'(i_read_byte_valid), 8'(w.rvalid));
            compare_field("message_length", 8'(i_message_length), 8'(w.length));
            compare_field("last_of_run", 8'(i_last_of_run), 8'(w.last));
            compare_field("pages_used", 8'(i_pages_used), 8'(w.used));
        end
        results++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            page_bytes_reg = PB_W'(MAX_PAGE_BYTES);
            pages_reg = PIU_W'(MAX_PAGES);
            clear_ring();
            expected_words.delete();
        end else begin
            // An output word can never come from an input word taken at the same edge.
            if (i_out_valid && i_out_ready) check_word();
            if (i_cfg_we) apply_register(i_cfg_idx, i_cfg_data);
            if (i_in_valid && i_in_ready) begin
                predict_word(i_opcode, i_data_byte, i_byte_present, i_end_of_message);
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_words.size();
        o_results_seen <= results;
    end

endmodule

FILE: bench/paged_packet_fifo_unit_test.sv
module paged_packet_fifo_unit_test;
    import ppf_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 80;
    localparam int LIMIT_CYCLES  = 2000000;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 37;

    // Register indexes the block does not decode.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  opcode = OP_WRITE;
    logic [7:0]            data_byte = '0;
    logic                  byte_present = 1'b0;
    logic                  end_of_message = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            status;
    logic [7:0]            read_byte;
    logic                  read_byte_valid;
    logic [MLEN_W-1:0]     message_length;
    logic                  last_of_run;
    logic [PU_W-1:0]       pages_used;

    int fail_count;
    int pending;
    int results_seen;
    int items_sent = 0;
    int burst_left = 1;
    int gap_max = 0;
    int page_limit = MAX_PAGE_BYTES;
    int register_writes = 0;
    int hold_requests = 0;
    bit recv_stalls = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    paged_packet_fifo_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_data_byte      (data_byte),
        .i_byte_present   (byte_present),
        .i_end_of_message (end_of_message),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (status),
        .o_read_byte      (read_byte),
        .o_read_byte_valid(read_byte_valid),
        .o_message_length (message_length),
        .o_last_of_run    (last_of_run),
        .o_pages_used     (pages_used)
    );

    ppf_word_checker fifo_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_opcode         (opcode),
        .i_data_byte      (data_byte),
        .i_byte_present   (byte_present),
        .i_end_of_message (end_of_message),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_status         (status),
        .i_read_byte      (read_byte),
        .i_read_byte_valid(read_byte_valid),
        .i_message_length (message_length),
        .i_last_of_run    (last_of_run),
        .i_pages_used     (pages_used),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_results_seen   (results_seen)
    );

    // Offers one word and returns at the edge that accepts it. Valid stays high into the
    // next word unless the current burst ends with a gap.
    task automatic send_word(input logic op, input logic [7:0] data, input logic present,
                             input logic eom);
        int gap;
        in_valid <= 1'b1;
        opcode <= op;
        data_byte <= data;
        byte_present <= present;
        end_of_message <= eom;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stray empty words are mixed in; they carry no byte and do not end the message.
    task automatic send_message(input int nbytes, input bit leave_open);
        bit close_on_byte;
        close_on_byte = !leave_open && nbytes > 0 && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 15) == 0) send_word(OP_WRITE, 8'($urandom), 1'b0, 1'b0);
            send_word(OP_WRITE, 8'($urandom), 1'b1, close_on_byte && i == nbytes - 1);
        end
        if (!leave_open && !close_on_byte) send_word(OP_WRITE, 8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(page_limit, page_limit + 3);
        if (r < 3) return 0;
        return $urandom_range(1, (page_limit < 8) ? page_limit + 1 : 8);
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_PAGE_BYTES) begin
            page_limit = (value == 0) ? 1 : (value > MAX_PAGE_BYTES) ? MAX_PAGE_BYTES : value;
        end
        register_writes++;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] bytes_val,
                             input logic [CFG_DATA_W-1:0] pages_val);
        write_register(REG_PAGE_BYTES, bytes_val);
        write_register(REG_PAGES_IN_USE, pages_val);
    endtask

    // Stops offering words until every predicted word has come out, then idles a little.
    task automatic settle(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    initial begin : output_side
        int served;
        served = 0;
        @(posedge clk);
        forever begin
            if (hold_requests != served) begin
                served++;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (!recv_stalls) begin
                out_ready <= 1'b1;
                @(posedge clk);
            end else begin
                out_ready <= ($urandom_range(0, 2) != 0);
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int stop_at;
        int r;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty FIFO, a zero-length page, and bytes at the extremes.
        send_word(OP_READ, 8'h00, 1'b0, 1'b0);
        send_word(OP_WRITE, 8'h00, 1'b0, 1'b1);
        send_word(OP_READ, 8'hFF, 1'b1, 1'b1);
        send_word(OP_WRITE, 8'h00, 1'b1, 1'b0);
        send_word(OP_WRITE, 8'hFF, 1'b1, 1'b0);
        send_word(OP_WRITE, 8'hA5, 1'b1, 1'b1);
        send_word(OP_READ, 8'h00, 1'b0, 1'b0);

        // A stored page keeps its length when the page size shrinks under an open message.
        send_word(OP_WRITE, 8'h5A, 1'b1, 1'b0);
        send_word(OP_WRITE, 8'hC3, 1'b1, 1'b0);
        send_word(OP_WRITE, 8'h3C, 1'b1, 1'b0);
        send_word(OP_WRITE, 8'h81, 1'b1, 1'b1);
        for (int i = 0; i < 5; i++) send_word(OP_WRITE, 8'(8'h10 + i), 1'b1, 1'b0);
        settle(SETTLE_CYCLES);
        write_register(REG_PAGE_BYTES, 7'd2);
        send_word(OP_WRITE, 8'h00, 1'b0, 1'b1);
        send_word(OP_READ, 8'h00, 1'b0, 1'b0);
        send_word(OP_READ, 8'h00, 1'b0, 1'b0);
        settle(SETTLE_CYCLES);

        // Single page: a byte that meets a full FIFO dooms its message even after a read.
        configure(7'd2, 7'd1);
        send_word(OP_WRITE, 8'h7E, 1'b1, 1'b1);
        send_word(OP_WRITE, 8'h42, 1'b1, 1'b0);
        send_word(OP_READ, 8'h00, 1'b0, 1'b0);
        send_word(OP_WRITE, 8'h00, 1'b0, 1'b1);
        send_word(OP_WRITE, 8'h00, 1'b0, 1'b1);
        send_word(OP_WRITE, 8'h99, 1'b1, 1'b1);
        send_word(OP_READ, 8'h00, 1'b0, 1'b0);
        send_word(OP_READ, 8'h00, 1'b0, 1'b0);
        settle(SETTLE_CYCLES);

        // Fill some pages, then read them out while the output side holds off.
        configure(7'd64, 7'd16);
        recv_stalls = 1'b1;
        gap_max = 3;
        repeat (8) send_message($urandom_range(4, 12), 1'b0);
        settle(SETTLE_CYCLES);
        hold_requests++;
        repeat (8) send_word(OP_READ, 8'($urandom), 1'($urandom), 1'($urandom));
        repeat (3) send_message($urandom_range(1, 6), 1'b0);
        settle(SETTLE_CYCLES);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: configure(7'd127, 7'd31);
                1: configure(7'd3, 7'd2);
                2: configure(7'd0, 7'd0);
                3: configure(7'd64, 7'd16);
                4: configure(7'd10, 7'd5);
                5: configure(7'd1, 7'b1100011);
                6: configure(7'd6, 7'd4);
                default: configure(7'd33, 7'd8);
            endcase
            write_register((p % 2 == 1) ? REG_SPARE_B : REG_SPARE_A, 7'($urandom));
            recv_stalls = (p != 3);
            gap_max = (p == 3 || p == 6) ? 0 : 5;
            stop_at = items_sent + PHASE_WORDS;
            while (items_sent < stop_at) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    send_message(pick_length(), 1'b0);
                end else if (r < 90) begin
                    send_word(OP_READ, 8'($urandom), 1'($urandom), 1'($urandom));
                end else begin
                    send_word(OP_WRITE, 8'($urandom), 1'($urandom), 1'($urandom));
                end
            end
            // Sometimes a message stays open across the register writes that follow.
            if ($urandom_range(0, 1) == 1) send_message(pick_length() + 1, 1'b1);
            settle(SETTLE_CYCLES);
        end

        settle(TAIL_CYCLES);
        $display("Sent %0d input words, checked %0d result words over %0d register writes.",
                 items_sent, results_seen, register_writes);
        $display("Covered empty and full rings, truncated, dropped and rejected messages, "
                 , "and a long output hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 12);
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ppf_pkg.sv
hdl/paged_packet_fifo_unit.sv
hdl/ppf_checker.sv
bench/ppf_word_checker.sv
bench/paged_packet_fifo_unit_test.sv
